[rtl/decimal_text_number_parser_top_assert.svh]
// Assertion macros used by the decimal text number parser core module.
`ifndef DECIMAL_TEXT_NUMBER_PARSER_TOP_ASSERT_SVH
`define DECIMAL_TEXT_NUMBER_PARSER_TOP_ASSERT_SVH

// Checks a property at every clock edge outside reset.
`define DTNP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define DTNP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dtnp_pkg.sv]
// Shared types, constants and helper functions of the decimal text number parser.
package dtnp_pkg;

    localparam int INT_DIGITS_DEF  = 9;
    localparam int FRAC_DIGITS_DEF = 9;

    localparam int CHAR_W  = 8;
    localparam int PART_W  = 30;
    localparam int FCOUT_W = 4;
    localparam int CFG_W   = 16;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'd46;

    localparam logic [CFG_W-1:0] BATCH_RESET = 16'd1;

    typedef struct packed {
        logic               negative;
        logic [PART_W-1:0]  integer_part;
        logic [PART_W-1:0]  fraction_value;
        logic [FCOUT_W-1:0] fraction_digits;
        logic               integer_overflow;
        logic               last_of_batch;
    } result_t;

    // Ten to the power n, evaluated at elaboration for accumulator sizing.
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] v;
        v = 64'd1;
        for (int k = 0; k < n; k++) begin
            v = v * 64'd10;
        end
        return v;
    endfunction

endpackage

[rtl/dtnp_in_stage.sv]
// Input register that holds one accepted character until the parser takes it.
module dtnp_in_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [dtnp_pkg::CHAR_W-1:0]  s_character,
    input  logic                         item_take,
    output logic                         item_valid,
    output logic [dtnp_pkg::CHAR_W-1:0]  item_char
);

    logic                        valid_reg, valid_next;
    logic [dtnp_pkg::CHAR_W-1:0] char_reg, char_next;

    // A new character may enter when the slot is empty or is being drained.
    assign s_ready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        char_next  = char_reg;
        if (s_ready) begin
            valid_next = s_valid;
            if (s_valid) begin
                char_next = s_character;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        char_reg <= char_next;
    end

    assign item_valid = valid_reg;
    assign item_char  = char_reg;

endmodule

[rtl/dtnp_core.sv]
// Parser state, combinational character step logic and the batch counter.
module dtnp_core #(
    parameter int INT_DIGITS  = dtnp_pkg::INT_DIGITS_DEF,
    parameter int FRAC_DIGITS = dtnp_pkg::FRAC_DIGITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [dtnp_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                         item_valid,
    input  logic [dtnp_pkg::CHAR_W-1:0]  item_char,
    input  logic                         out_free,
    output logic                         item_take,
    output logic                         res_load,
    output dtnp_pkg::result_t            res_data
);

`include "decimal_text_number_parser_top_assert.svh"

    localparam int INT_W  = $clog2(dtnp_pkg::pow10(INT_DIGITS));
    localparam int FRAC_W = $clog2(dtnp_pkg::pow10(FRAC_DIGITS));
    localparam int FCNT_W = $clog2(FRAC_DIGITS + 1);
    localparam logic [INT_W+3:0] INT_LIMIT =
        (INT_W+4)'(dtnp_pkg::pow10(INT_DIGITS) - 64'd1);
    localparam logic [FCNT_W-1:0] FRAC_MAX = FCNT_W'(FRAC_DIGITS);

    typedef enum logic [2:0] {
        PH_SEEK = 3'b001,
        PH_INT  = 3'b010,
        PH_FRAC = 3'b100
    } phase_t;

    phase_t                     phase_reg, phase_next;
    logic                       sign_reg, sign_next;
    logic [INT_W-1:0]           int_acc_reg, int_acc_next;
    logic                       ovf_reg, ovf_next;
    logic [FRAC_W-1:0]          frac_acc_reg, frac_acc_next;
    logic [FCNT_W-1:0]          frac_cnt_reg, frac_cnt_next;
    logic [dtnp_pkg::CFG_W-1:0] emitted_reg, emitted_next;
    logic [dtnp_pkg::CFG_W-1:0] batch_reg;

    logic                       is_digit;
    logic                       is_minus;
    logic                       is_dot;
    logic [3:0]                 digit_val;
    logic [INT_W+3:0]           int_sum;
    logic [FRAC_W+3:0]          frac_sum;
    logic [dtnp_pkg::CFG_W:0]   emitted_inc;
    logic [dtnp_pkg::CFG_W-1:0] batch_eff;
    logic                       last;
    logic                       emit;
    logic                       in_int;
    logic                       in_frac;
    logic [63:0]                int_ext;
    logic [63:0]                frac_ext;
    logic [7:0]                 fcnt_ext;

    assign is_digit  = (item_char inside {[dtnp_pkg::CH_ZERO:dtnp_pkg::CH_NINE]});
    assign is_minus  = (item_char == dtnp_pkg::CH_MINUS);
    assign is_dot    = (item_char == dtnp_pkg::CH_DOT);
    assign digit_val = is_digit ? item_char[3:0] : 4'd0;

    // Multiply by ten as two shifted copies, then add the new digit.
    assign int_sum  = {int_acc_reg, 3'b000} + {2'b00, int_acc_reg, 1'b0}
                    + (INT_W+4)'(digit_val);
    assign frac_sum = {frac_acc_reg, 3'b000} + {2'b00, frac_acc_reg, 1'b0}
                    + (FRAC_W+4)'(digit_val);

    // A batch size of zero behaves as a size of one.
    assign batch_eff   = (batch_reg == '0) ? dtnp_pkg::CFG_W'(1) : batch_reg;
    assign emitted_inc = {1'b0, emitted_reg} + (dtnp_pkg::CFG_W+1)'(1);
    assign last        = (emitted_inc >= {1'b0, batch_eff});

    always_comb begin
        phase_next    = phase_reg;
        sign_next     = sign_reg;
        int_acc_next  = int_acc_reg;
        ovf_next      = ovf_reg;
        frac_acc_next = frac_acc_reg;
        frac_cnt_next = frac_cnt_reg;
        emitted_next  = emitted_reg;
        emit          = 1'b0;
        in_int        = 1'b0;
        in_frac       = 1'b0;

        case (phase_reg)
            PH_INT: begin
                in_int = 1'b1;
            end
            PH_FRAC: begin
                in_frac = 1'b1;
            end
            default: begin
                if (is_digit) begin
                    sign_next  = 1'b0;
                    phase_next = PH_INT;
                    in_int     = 1'b1;
                end else if (is_minus) begin
                    sign_next  = 1'b1;
                    phase_next = PH_INT;
                end
            end
        endcase

        if (in_int) begin
            if (is_digit) begin
                if (!ovf_reg) begin
                    if (int_sum > INT_LIMIT) begin
                        int_acc_next = INT_LIMIT[INT_W-1:0];
                        ovf_next     = 1'b1;
                    end else begin
                        int_acc_next = int_sum[INT_W-1:0];
                    end
                end
            end else begin
                // The first non-digit is looked at again as a fraction character.
                phase_next = PH_FRAC;
                in_frac    = 1'b1;
            end
        end

        if (in_frac) begin
            if (is_digit) begin
                if (frac_cnt_reg < FRAC_MAX) begin
                    frac_acc_next = frac_sum[FRAC_W-1:0];
                    frac_cnt_next = frac_cnt_reg + FCNT_W'(1);
                end
            end else if (!is_dot) begin
                emit = 1'b1;
            end
        end

        if (emit) begin
            phase_next    = PH_SEEK;
            sign_next     = 1'b0;
            int_acc_next  = '0;
            ovf_next      = 1'b0;
            frac_acc_next = '0;
            frac_cnt_next = '0;
            if (last) begin
                emitted_next = '0;
            end else begin
                emitted_next = emitted_inc[dtnp_pkg::CFG_W-1:0];
                // Within a batch, a minus sign that ends a value opens the next one.
                if (is_minus) begin
                    sign_next  = 1'b1;
                    phase_next = PH_INT;
                end
            end
        end
    end

    // The character is taken unless it produces a value that cannot be stored yet.
    assign item_take = item_valid && (!emit || out_free);
    assign res_load  = item_take && emit;

    assign int_ext  = 64'(int_acc_reg);
    assign frac_ext = 64'(frac_acc_reg);
    assign fcnt_ext = 8'(frac_cnt_reg);

    always_comb begin
        res_data.negative         = sign_reg;
        res_data.integer_part     = int_ext[dtnp_pkg::PART_W-1:0];
        res_data.fraction_value   = frac_ext[dtnp_pkg::PART_W-1:0];
        res_data.fraction_digits  = fcnt_ext[dtnp_pkg::FCOUT_W-1:0];
        res_data.integer_overflow = ovf_reg;
        res_data.last_of_batch    = last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SEEK;
            sign_reg     <= 1'b0;
            int_acc_reg  <= '0;
            ovf_reg      <= 1'b0;
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
            emitted_reg  <= '0;
            batch_reg    <= dtnp_pkg::BATCH_RESET;
        end else begin
            if (item_take) begin
                phase_reg    <= phase_next;
                sign_reg     <= sign_next;
                int_acc_reg  <= int_acc_next;
                ovf_reg      <= ovf_next;
                frac_acc_reg <= frac_acc_next;
                frac_cnt_reg <= frac_cnt_next;
                emitted_reg  <= emitted_next;
            end
            if (cfg_wr_en) begin
                batch_reg <= cfg_wr_data;
            end
        end
    end

    `DTNP_ASSERT(a_ovf_saturated, !ovf_reg || (int_acc_reg == INT_LIMIT[INT_W-1:0]), "overflow set but integer not at limit")
    `DTNP_ASSERT(a_frac_count_bound, frac_cnt_reg <= FRAC_MAX, "fraction digit count beyond limit")
    `DTNP_ASSERT_NEXT(a_batch_restart, res_load && last, emitted_reg == '0, "batch count did not restart")
    `DTNP_ASSERT_NEXT(a_emit_clears, res_load && !is_minus, (phase_reg == PH_SEEK) && !ovf_reg && (frac_cnt_reg == '0), "number state not cleared after value")

endmodule

[rtl/dtnp_out_stage.sv]
// Result register that holds one parsed value until the transfer completes.
module dtnp_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          res_load,
    input  dtnp_pkg::result_t             res_data,
    output logic                          out_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_negative,
    output logic [dtnp_pkg::PART_W-1:0]   m_integer_part,
    output logic [dtnp_pkg::PART_W-1:0]   m_fraction_value,
    output logic [dtnp_pkg::FCOUT_W-1:0]  m_fraction_digits,
    output logic                          m_integer_overflow,
    output logic                          m_last_of_batch
);

    logic              valid_reg, valid_next;
    dtnp_pkg::result_t data_reg, data_next;

    // The register can take a new value when empty or when its transfer completes now.
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (out_free) begin
            valid_next = res_load;
        end
        if (res_load) begin
            data_next = res_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_valid            = valid_reg;
    assign m_negative         = data_reg.negative;
    assign m_integer_part     = data_reg.integer_part;
    assign m_fraction_value   = data_reg.fraction_value;
    assign m_fraction_digits  = data_reg.fraction_digits;
    assign m_integer_overflow = data_reg.integer_overflow;
    assign m_last_of_batch    = data_reg.last_of_batch;

endmodule

[rtl/decimal_text_number_parser_top.sv]
// Top level of the ASCII decimal number parser: input register, parser step, result register.
// Takes one ASCII character per cycle and returns each signed decimal number it finds as
// sign, saturated integer part, fraction digits read as an integer, and their count.
// A character accepted into the input register is parsed from there, and a value that it
// ends is loaded into the result register as the parser takes that character and is offered
// on the m_ channel from there. One character per cycle is sustained by the combinational
// multiply-by-ten accumulate of the parser step; s_ready drops only while a terminating
// character waits for a transfer to free the result register. The user must write
// values_per_batch through cfg_wr_en and cfg_wr_data while the block is idle; not enforced.
module decimal_text_number_parser_top #(
    parameter int INT_DIGITS  = dtnp_pkg::INT_DIGITS_DEF,
    parameter int FRAC_DIGITS = dtnp_pkg::FRAC_DIGITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dtnp_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dtnp_pkg::CHAR_W-1:0]   s_character,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_negative,
    output logic [dtnp_pkg::PART_W-1:0]   m_integer_part,
    output logic [dtnp_pkg::PART_W-1:0]   m_fraction_value,
    output logic [dtnp_pkg::FCOUT_W-1:0]  m_fraction_digits,
    output logic                          m_integer_overflow,
    output logic                          m_last_of_batch
);

    logic                        item_take;
    logic                        item_valid;
    logic [dtnp_pkg::CHAR_W-1:0] item_char;
    logic                        out_free;
    logic                        res_load;
    dtnp_pkg::result_t           res_data;

    dtnp_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .item_take   (item_take),
        .item_valid  (item_valid),
        .item_char   (item_char)
    );

    dtnp_core #(
        .INT_DIGITS  (INT_DIGITS),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_char   (item_char),
        .out_free    (out_free),
        .item_take   (item_take),
        .res_load    (res_load),
        .res_data    (res_data)
    );

    dtnp_out_stage u_out_stage (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .res_load           (res_load),
        .res_data           (res_data),
        .out_free           (out_free),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_negative         (m_negative),
        .m_integer_part     (m_integer_part),
        .m_fraction_value   (m_fraction_value),
        .m_fraction_digits  (m_fraction_digits),
        .m_integer_overflow (m_integer_overflow),
        .m_last_of_batch    (m_last_of_batch)
    );

endmodule

[tb/number_parse_checker.sv]
// Checker for the decimal text number parser: predicts each parsed value and compares it.
module number_parse_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dtnp_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [dtnp_pkg::CHAR_W-1:0]   s_character,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_negative,
    input  logic [dtnp_pkg::PART_W-1:0]   m_integer_part,
    input  logic [dtnp_pkg::PART_W-1:0]   m_fraction_value,
    input  logic [dtnp_pkg::FCOUT_W-1:0]  m_fraction_digits,
    input  logic                          m_integer_overflow,
    input  logic                          m_last_of_batch,
    output int                            mismatch_count,
    output int                            expected_count
);

    // The block is built with its default digit limits.
    localparam logic [63:0] INTEGER_MAX = 64'd999_999_999;
    localparam int          FRACTION_MAX = dtnp_pkg::FRAC_DIGITS_DEF;

    typedef enum logic [1:0] {
        SEEK        = 2'd0,
        IN_INTEGER  = 2'd1,
        IN_FRACTION = 2'd2
    } parse_phase_t;

    parse_phase_t                 phase;
    logic                         negative;
    logic [63:0]                  integer_acc;
    logic                         overflowed;
    logic [63:0]                  fraction_acc;
    logic [3:0]                   fraction_count;
    logic [dtnp_pkg::CFG_W-1:0]   values_emitted;
    logic [dtnp_pkg::CFG_W-1:0]   batch_size;
    dtnp_pkg::result_t            expected_numbers[$];

    assign expected_count = expected_numbers.size();

    initial begin
        mismatch_count = 0;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        mismatch_count++;
        $display("ERROR at %0t: %s got %0d, wanted %0d", $time, what, got, want);
    endtask

    task automatic clear_number();
        phase = SEEK;
        negative = 1'b0;
        integer_acc = '0;
        overflowed = 1'b0;
        fraction_acc = '0;
        fraction_count = '0;
    endtask

    task automatic parse_char(input logic [dtnp_pkg::CHAR_W-1:0] ch);
        logic              is_digit;
        logic [63:0]       digit_value;
        logic [63:0]       grown;
        logic [16:0]       batch_limit;
        logic              ends_batch;
        dtnp_pkg::result_t value;
        is_digit = (ch >= dtnp_pkg::CH_ZERO) && (ch <= dtnp_pkg::CH_NINE);
        digit_value = is_digit ? 64'(ch - dtnp_pkg::CH_ZERO) : 64'd0;

        if (phase == SEEK) begin
            if (is_digit) begin
                negative = 1'b0;
                phase = IN_INTEGER;
            end else if (ch == dtnp_pkg::CH_MINUS) begin
                negative = 1'b1;
                phase = IN_INTEGER;
                return;
            end else begin
                return;
            end
        end

        if (phase == IN_INTEGER) begin
            if (is_digit) begin
                if (!overflowed) begin
                    grown = integer_acc * 64'd10 + digit_value;
                    if (grown > INTEGER_MAX) begin
                        integer_acc = INTEGER_MAX;
                        overflowed = 1'b1;
                    end else begin
                        integer_acc = grown;
                    end
                end
                return;
            end
            // The first non-digit is looked at again as a fraction character.
            phase = IN_FRACTION;
        end

        if (is_digit) begin
            if (fraction_count < FRACTION_MAX) begin
                fraction_acc = fraction_acc * 64'd10 + digit_value;
                fraction_count++;
            end
            return;
        end
        if (ch == dtnp_pkg::CH_DOT) begin
            return;
        end

        batch_limit = (batch_size == '0) ? 17'd1 : {1'b0, batch_size};
        ends_batch = ({1'b0, values_emitted} + 17'd1) >= batch_limit;

        value.negative = negative;
        value.integer_part = integer_acc[dtnp_pkg::PART_W-1:0];
        value.fraction_value = fraction_acc[dtnp_pkg::PART_W-1:0];
        value.fraction_digits = fraction_count;
        value.integer_overflow = overflowed;
        value.last_of_batch = ends_batch;
        expected_numbers.push_back(value);

        clear_number();
        if (ends_batch) begin
            values_emitted = '0;
        end else begin
            values_emitted = values_emitted + 1'b1;
            // Outside a batch end the terminator may open the next number.
            if (ch == dtnp_pkg::CH_MINUS) begin
                negative = 1'b1;
                phase = IN_INTEGER;
            end
        end
    endtask

    task automatic check_number();
        dtnp_pkg::result_t want;
        if (expected_numbers.size() == 0) begin
            report("value with none expected, integer_part", m_integer_part, 0);
            return;
        end
        want = expected_numbers.pop_front();
        if (m_negative !== want.negative)
            report("negative", m_negative, want.negative);
        if (m_integer_part !== want.integer_part)
            report("integer_part", m_integer_part, want.integer_part);
        if (m_fraction_value !== want.fraction_value)
            report("fraction_value", m_fraction_value, want.fraction_value);
        if (m_fraction_digits !== want.fraction_digits)
            report("fraction_digits", m_fraction_digits, want.fraction_digits);
        if (m_integer_overflow !== want.integer_overflow)
            report("integer_overflow", m_integer_overflow, want.integer_overflow);
        if (m_last_of_batch !== want.last_of_batch)
            report("last_of_batch", m_last_of_batch, want.last_of_batch);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_number();
            values_emitted = '0;
            batch_size = dtnp_pkg::BATCH_RESET;
            expected_numbers.delete();
        end else begin
            if (cfg_wr_en) begin
                batch_size = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                parse_char(s_character);
            end
            if (m_valid && m_ready) begin
                check_number();
            end
        end
    end

endmodule

[tb/tb_decimal_text_number_parser_top.sv]
// Testbench top for the decimal text number parser: stimulus, idling phases and verdict.
module tb_decimal_text_number_parser_top;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [dtnp_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [dtnp_pkg::CHAR_W-1:0]    s_character = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_negative;
    logic [dtnp_pkg::PART_W-1:0]    m_integer_part;
    logic [dtnp_pkg::PART_W-1:0]    m_fraction_value;
    logic [dtnp_pkg::FCOUT_W-1:0]   m_fraction_digits;
    logic                           m_integer_overflow;
    logic                           m_last_of_batch;

    int mismatch_count;
    int expected_count;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int chars_sent = 0;

    always #1 aclk = ~aclk;

    decimal_text_number_parser_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_character        (s_character),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_negative         (m_negative),
        .m_integer_part     (m_integer_part),
        .m_fraction_value   (m_fraction_value),
        .m_fraction_digits  (m_fraction_digits),
        .m_integer_overflow (m_integer_overflow),
        .m_last_of_batch    (m_last_of_batch)
    );

    number_parse_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_character        (s_character),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_negative         (m_negative),
        .m_integer_part     (m_integer_part),
        .m_fraction_value   (m_fraction_value),
        .m_fraction_digits  (m_fraction_digits),
        .m_integer_overflow (m_integer_overflow),
        .m_last_of_batch    (m_last_of_batch),
        .mismatch_count     (mismatch_count),
        .expected_count     (expected_count)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Returns at the edge where the character transfer takes place.
    task automatic send_char(input logic [dtnp_pkg::CHAR_W-1:0] ch);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_character <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i]);
        end
    endtask

    // Stops sending until every predicted value has been received, then lets the pipe settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (expected_count != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_batch_size(input logic [dtnp_pkg::CFG_W-1:0] size);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [dtnp_pkg::CHAR_W-1:0] random_digit();
        return dtnp_pkg::CH_ZERO + dtnp_pkg::CHAR_W'($urandom_range(0, 9));
    endfunction

    // Any byte that can end a number: neither a digit nor a dot.
    function automatic logic [dtnp_pkg::CHAR_W-1:0] random_separator();
        logic [dtnp_pkg::CHAR_W-1:0] ch;
        do begin
            ch = dtnp_pkg::CHAR_W'($urandom_range(0, 255));
        end while ((ch >= dtnp_pkg::CH_ZERO && ch <= dtnp_pkg::CH_NINE)
                   || ch == dtnp_pkg::CH_DOT);
        return ch;
    endfunction

    task automatic send_number();
        int  shape;
        int  int_len;
        int  frac_len;
        bit  all_nines;
        shape = $urandom_range(0, 9);
        all_nines = (shape == 9) && ($urandom_range(0, 1) == 1);
        int_len = (shape == 0) ? 0 : (shape < 8) ? $urandom_range(1, 4) : $urandom_range(8, 12);
        if ($urandom_range(0, 3) == 0) begin
            send_char(dtnp_pkg::CH_MINUS);
        end
        for (int i = 0; i < int_len; i++) begin
            send_char(all_nines ? dtnp_pkg::CH_NINE : random_digit());
        end
        if ($urandom_range(0, 2) != 0) begin
            send_char(dtnp_pkg::CH_DOT);
            frac_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
            for (int i = 0; i < frac_len; i++) begin
                send_char(random_digit());
                if ($urandom_range(0, 19) == 0) begin
                    send_char(dtnp_pkg::CH_DOT);
                end
            end
        end
        case ($urandom_range(0, 4))
            0: send_char(8'd44);
            1: send_char(8'd32);
            2: send_char(dtnp_pkg::CH_MINUS);
            3: send_char(8'd10);
            default: send_char(random_separator());
        endcase
    endtask

    initial begin
        logic [dtnp_pkg::CFG_W-1:0] batch_sizes[6];
        int                         target;
        batch_sizes = '{16'd3, 16'd65535, 16'd0, 16'd1, 16'd7, 16'd2};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, batch size one after reset.
        send_text(".7x");
        send_char(8'h00);
        send_char(8'hFF);
        send_text("--3,");
        send_text("0.000000000,");
        send_text("999999999,");
        send_text("9999999999.1234567891,");
        send_text("1..5 -.25,");
        wait_drained();
        // With batches of three a minus that ends a value opens the next one, except at a batch end.
        write_batch_size(16'd3);
        send_text("1-2-3-4,");
        wait_drained();
        write_batch_size(16'd5);
        send_text("1,2,3,");
        wait_drained();
        // Lowered below the count already reached: the next value ends the batch.
        write_batch_size(16'd2);
        send_text("6,");
        wait_drained();
        write_batch_size(16'd0);
        send_text("8,9,");

        for (int seg = 0; seg < 6; seg++) begin
            wait_drained();
            write_batch_size(batch_sizes[seg]);
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            target = chars_sent + 310;
            while (chars_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_char(dtnp_pkg::CHAR_W'($urandom_range(0, 255)));
                end else begin
                    send_number();
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/dtnp_pkg.sv
rtl/dtnp_in_stage.sv
rtl/dtnp_core.sv
rtl/dtnp_out_stage.sv
rtl/decimal_text_number_parser_top.sv
tb/number_parse_checker.sv
tb/tb_decimal_text_number_parser_top.sv
